@@ rtl/greedy_nearest_point_matcher_unit_assert.svh @@
// assertion macros shared by the rtl
`ifndef GREEDY_NEAREST_POINT_MATCHER_UNIT_ASSERT_SVH
`define GREEDY_NEAREST_POINT_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define GNPM_ASSERT_NOW(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("gnpm assertion failed");

// condition must hold in the cycle after the trigger
`define GNPM_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("gnpm assertion failed");

`else

`define GNPM_ASSERT_NOW(label, clk, rstn, trig, cond)
`define GNPM_ASSERT_NEXT(label, clk, rstn, trig, cond)

`endif

`endif

@@ rtl/gnpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gnpm_pkg;

    localparam int TABLE_DEPTH    = 4096;
    localparam int COORD_BITS     = 16;
    localparam int ADDR_BITS      = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS     = $clog2(TABLE_DEPTH + 1);
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int DIST_BITS      = 2 * COORD_BITS + 1;
    localparam int RADIUS_BITS    = 16;
    localparam int INDEX_OUT_BITS = 12;
    localparam int NUMBER_OUT_BITS = 13;

    typedef logic [1:0]                 func_t;
    typedef logic [ADDR_BITS-1:0]       addr_t;
    typedef logic [COUNT_BITS-1:0]      count_t;
    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [SQ_BITS-1:0]         sq_t;
    typedef logic [DIST_BITS-1:0]       dist_t;
    typedef logic [INDEX_OUT_BITS-1:0]  index_out_t;
    typedef logic [NUMBER_OUT_BITS-1:0] number_out_t;

    localparam func_t FUNC_APPEND = 2'd0;
    localparam func_t FUNC_QUERY  = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;
    localparam func_t FUNC_EMPTY  = 2'd3;

    // one write into the point store
    typedef struct packed {
        logic   coord_we;
        logic   taken_we;
        addr_t  addr;
        coord_t x;
        coord_t y;
        logic   taken;
    } store_wr_t;

    // one entry as read back from the store
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   taken;
    } ref_entry_t;

    // travels alongside each scan read
    typedef struct packed {
        logic  valid;
        logic  last;
        addr_t idx;
    } scan_tag_t;

    // running best candidate of a scan
    typedef struct packed {
        logic  found;
        addr_t idx;
        dist_t min_dist;
    } best_t;

endpackage

`default_nettype wire

@@ rtl/gnpm_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gnpm_store (
    input  wire logic                  aclk,
    input  wire logic                  rd_en,
    input  wire gnpm_pkg::addr_t       rd_addr,
    input  wire gnpm_pkg::store_wr_t   wr,
    output gnpm_pkg::ref_entry_t       rd_entry
);

    // coordinates and taken marks, both read through an output register
    logic [gnpm_pkg::SQ_BITS-1:0] coord_mem [gnpm_pkg::TABLE_DEPTH];
    logic                         taken_mem [gnpm_pkg::TABLE_DEPTH];

    logic [gnpm_pkg::SQ_BITS-1:0] coord_rd_reg;
    logic                         taken_rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.coord_we) begin
            coord_mem[wr.addr] <= {wr.x, wr.y};
        end
        if (rd_en) begin
            coord_rd_reg <= coord_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.taken_we) begin
            taken_mem[wr.addr] <= wr.taken;
        end
        if (rd_en) begin
            taken_rd_reg <= taken_mem[rd_addr];
        end
    end

    // x in the upper half, y in the lower half, then the mark
    assign rd_entry = {coord_rd_reg, taken_rd_reg};

endmodule

`default_nettype wire

@@ rtl/gnpm_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gnpm_dist (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire gnpm_pkg::scan_tag_t   tag_in,
    input  wire gnpm_pkg::ref_entry_t  entry_in,
    input  wire gnpm_pkg::coord_t      query_x,
    input  wire gnpm_pkg::coord_t      query_y,
    output gnpm_pkg::best_t            best,
    output logic                       done
);

    // stage a: absolute differences
    gnpm_pkg::scan_tag_t tag_a_reg;
    logic                taken_a_reg;
    gnpm_pkg::coord_t    dx_a_reg;
    gnpm_pkg::coord_t    dy_a_reg;

    // stage b: squares
    gnpm_pkg::scan_tag_t tag_b_reg;
    logic                taken_b_reg;
    gnpm_pkg::sq_t       sx_b_reg;
    gnpm_pkg::sq_t       sy_b_reg;

    // stage c: running minimum
    gnpm_pkg::best_t     best_reg;
    gnpm_pkg::best_t     best_next;
    logic                done_reg;

    gnpm_pkg::dist_t     dist_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            done_reg  <= tag_b_reg.valid && tag_b_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        taken_a_reg <= entry_in.taken;
        dx_a_reg    <= (entry_in.x >= query_x) ? entry_in.x - query_x : query_x - entry_in.x;
        dy_a_reg    <= (entry_in.y >= query_y) ? entry_in.y - query_y : query_y - entry_in.y;
        taken_b_reg <= taken_a_reg;
        sx_b_reg    <= dx_a_reg * dx_a_reg;
        sy_b_reg    <= dy_a_reg * dy_a_reg;
    end

    assign dist_b = {1'b0, sx_b_reg} + {1'b0, sy_b_reg};

    // strict less keeps the lowest index on ties
    always_comb begin
        best_next = best_reg;
        if (start) begin
            best_next.found = 1'b0;
        end else if (tag_b_reg.valid && !taken_b_reg
                     && (!best_reg.found || dist_b < best_reg.min_dist)) begin
            best_next.found    = 1'b1;
            best_next.idx      = tag_b_reg.idx;
            best_next.min_dist = dist_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.found <= 1'b0;
        end else begin
            best_reg.found <= best_next.found;
        end
        best_reg.idx      <= best_next.idx;
        best_reg.min_dist <= best_next.min_dist;
    end

    assign best = best_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/greedy_nearest_point_matcher_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// greedy nearest point matcher
// input channel (s_*): one beat carries func and a point. func selects append
// reference, match query, clear marks and counter, or empty the table and counter.
// result channel (m_*): one beat per append or query, none for clear / empty.
// cfg_wr_en / cfg_wr_data write radius_limit (reset 160); the user must write it
// only while the unit is idle, the unit does not enforce this. an append answers
// once the output register is free. a query streams every stored entry through
// the single read port of the point store, one entry per cycle, into a distance
// pipeline. a clear-marks beat sweeps the taken marks of every stored entry.
// only one beat is worked on at a time; the next beat is taken once the unit is
// back in idle, even while the previous result still sits in the output register.
// reset: table empty, match counter zero, radius 160; the point store itself is
// not cleared, appends write each entry and its taken mark before any read.
// a stalled receiver holds the result in the output register; the unit then
// waits before producing the following result, nothing is dropped.

`include "greedy_nearest_point_matcher_unit_assert.svh"

module greedy_nearest_point_matcher_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_point_x,
    input  wire logic [15:0] s_point_y,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_matched,
    output logic [11:0]      m_ref_index,
    output logic [12:0]      m_match_number,
    output logic             m_table_full,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPEND = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;

    logic [2:0] state_reg, state_next;

    gnpm_pkg::count_t  count_reg, count_next;
    gnpm_pkg::count_t  counter_reg, counter_next;
    gnpm_pkg::addr_t   idx_reg, idx_next;
    gnpm_pkg::coord_t  qx_reg, qy_reg;
    logic [gnpm_pkg::RADIUS_BITS-1:0]   radius_reg;
    logic [2*gnpm_pkg::RADIUS_BITS-1:0] rsq_reg;

    // output register
    logic                     m_valid_reg;
    logic                     matched_reg;
    gnpm_pkg::index_out_t     index_reg;
    gnpm_pkg::number_out_t    number_reg;
    logic                     full_reg;
    logic                     out_load;
    logic                     out_free;
    logic                     load_matched;
    gnpm_pkg::index_out_t     load_index;
    gnpm_pkg::number_out_t    load_number;
    logic                     load_full;

    logic                     s_accept;
    logic                     idx_last;
    logic                     start;
    logic                     hit;
    logic                     table_is_full;

    gnpm_pkg::store_wr_t      wr;
    gnpm_pkg::ref_entry_t     rd_entry;
    gnpm_pkg::scan_tag_t      issue_tag;
    gnpm_pkg::scan_tag_t      tag_d1_reg;
    gnpm_pkg::best_t          best;
    logic                     scan_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_last  = ({1'b0, idx_reg} == count_reg - gnpm_pkg::count_t'(1));
    assign table_is_full = (count_reg == gnpm_pkg::count_t'(gnpm_pkg::TABLE_DEPTH));
    // a query hits when the nearest free entry lies strictly inside the radius
    assign hit = best.found && (best.min_dist < {1'b0, rsq_reg});
    // best candidate is reset as the query beat comes in
    assign start = s_accept && (s_func == gnpm_pkg::FUNC_QUERY);

    // read issue: one entry per cycle during the scan
    always_comb begin
        issue_tag.valid = (state_reg == ST_SCAN);
        issue_tag.last  = idx_last;
        issue_tag.idx   = idx_reg;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        counter_next = counter_reg;
        idx_next     = idx_reg;
        out_load     = 1'b0;
        load_matched = 1'b0;
        load_index   = '0;
        load_number  = gnpm_pkg::number_out_t'(counter_reg);
        load_full    = 1'b0;
        wr.coord_we  = 1'b0;
        wr.taken_we  = 1'b0;
        wr.addr      = idx_reg;
        wr.x         = qx_reg;
        wr.y         = qy_reg;
        wr.taken     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next = '0;
                    unique case (s_func)
                        gnpm_pkg::FUNC_APPEND: begin
                            state_next = ST_APPEND;
                        end
                        gnpm_pkg::FUNC_QUERY: begin
                            state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        gnpm_pkg::FUNC_CLEAR: begin
                            counter_next = '0;
                            state_next   = (count_reg == '0) ? ST_IDLE : ST_CLEAR;
                        end
                        gnpm_pkg::FUNC_EMPTY: begin
                            counter_next = '0;
                            count_next   = '0;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_APPEND: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    load_full = table_is_full;
                    if (!table_is_full) begin
                        // new entry starts untaken
                        wr.coord_we = 1'b1;
                        wr.taken_we = 1'b1;
                        wr.addr     = count_reg[gnpm_pkg::ADDR_BITS-1:0];
                        count_next  = count_reg + gnpm_pkg::count_t'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                idx_next = idx_reg + gnpm_pkg::addr_t'(1);
                if (idx_last) begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN: begin
                if (scan_done) begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    load_matched = hit;
                    if (hit) begin
                        wr.taken_we  = 1'b1;
                        wr.addr      = best.idx;
                        wr.taken     = 1'b1;
                        counter_next = counter_reg + gnpm_pkg::count_t'(1);
                        load_index   = gnpm_pkg::index_out_t'(best.idx);
                        load_number  = gnpm_pkg::number_out_t'(counter_next);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_CLEAR: begin
                wr.taken_we = 1'b1;
                idx_next    = idx_reg + gnpm_pkg::addr_t'(1);
                if (idx_last) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            counter_reg <= '0;
            idx_reg     <= '0;
            radius_reg  <= gnpm_pkg::RADIUS_BITS'(160);
            m_valid_reg <= 1'b0;
            tag_d1_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            counter_reg <= counter_next;
            idx_reg     <= idx_next;
            tag_d1_reg  <= issue_tag;
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        rsq_reg <= radius_reg * radius_reg;
        if (s_accept) begin
            qx_reg <= s_point_x;
            qy_reg <= s_point_y;
        end
        if (out_load) begin
            matched_reg <= load_matched;
            index_reg   <= load_index;
            number_reg  <= load_number;
            full_reg    <= load_full;
        end
    end

    gnpm_store u_store (
        .aclk     (aclk),
        .rd_en    (issue_tag.valid),
        .rd_addr  (idx_reg),
        .wr       (wr),
        .rd_entry (rd_entry)
    );

    gnpm_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .tag_in   (tag_d1_reg),
        .entry_in (rd_entry),
        .query_x  (qx_reg),
        .query_y  (qy_reg),
        .best     (best),
        .done     (scan_done)
    );

    assign m_valid        = m_valid_reg;
    assign m_matched      = matched_reg;
    assign m_ref_index    = index_reg;
    assign m_match_number = number_reg;
    assign m_table_full   = full_reg;

    // table never holds more than its depth
    `GNPM_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= gnpm_pkg::count_t'(gnpm_pkg::TABLE_DEPTH))
    // every match consumed a distinct stored entry
    `GNPM_ASSERT_NOW(a_counter_bound, aclk, aresetn, 1'b1, counter_reg <= count_reg)
    // a taken mark is only ever set on a stored entry
    `GNPM_ASSERT_NOW(a_mark_in_table, aclk, aresetn, wr.taken_we && wr.taken, {1'b0, wr.addr} < count_reg)
    // the distance pipeline reports the end of a scan only after issue stopped
    `GNPM_ASSERT_NOW(a_done_in_drain, aclk, aresetn, scan_done, state_reg == ST_DRAIN)
    // a matched result always raises the counter by one
    `GNPM_ASSERT_NEXT(a_match_counts, aclk, aresetn, out_load && load_matched, counter_reg == $past(counter_reg) + gnpm_pkg::count_t'(1))

endmodule

`default_nettype wire
